// ----- rtl/core/ptst_pkg.sv -----
// ----------------------------------------------------------------------------
// ptst_pkg
// Types and constants shared by the periodic task scheduler table modules.
// ----------------------------------------------------------------------------
package ptst_pkg;

    localparam int TAG_W       = 8;
    localparam int TIME_W      = 16;
    localparam int RUNS_W      = 8;
    localparam int SLOT_W      = 6;
    localparam int DEL_W       = 5;
    localparam int CODE_W      = 2;
    localparam int MAX_RUNS    = 32;
    localparam int RUN_CNT_W   = 6;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_DISPATCH = 2'd3
    } ptst_op_t;

    localparam logic [CODE_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [CODE_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [CODE_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [CODE_W-1:0] LATCH_NONE          = 2'd0;
    localparam logic [CODE_W-1:0] LATCH_TOO_MANY      = 2'd1;
    localparam logic [CODE_W-1:0] LATCH_CANNOT_DELETE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_DELETE,
        ST_WALK,
        ST_FINISH
    } ptst_state_t;

    // One slot as kept in the slot memory; the valid bits live in flops.
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [RUNS_W-1:0] pending;
    } ptst_entry_t;

    typedef struct packed {
        logic load;
        logic add_step;
        logic delete_step;
        logic walk_step;
        logic finish;
    } ptst_cmd_t;

    typedef struct packed {
        logic add_done;
        logic walk_done;
    } ptst_stat_t;

endpackage

// ----- rtl/core/periodic_task_scheduler_table.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler_table
// Add searches the valid bits one slot a cycle for the first free slot; delete
// needs no search; tick and dispatch walk the table one slot a cycle through the
// slot RAM port.
// One operation at a time; the next start is taken once busy falls.
// Reset empties the table at once through the valid bits; the receiver cannot stall.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_table #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [ptst_pkg::TAG_W-1:0]    task_tag,
    input  logic [ptst_pkg::TIME_W-1:0]   first_delay,
    input  logic [ptst_pkg::TIME_W-1:0]   repeat_period,
    input  logic [ptst_pkg::DEL_W-1:0]    slot_to_delete,
    output logic                          result_valid,
    output logic [ptst_pkg::SLOT_W-1:0]   slot_index,
    output logic [ptst_pkg::TAG_W-1:0]    run_tag,
    output logic                          run_valid,
    output logic [ptst_pkg::CODE_W-1:0]   status,
    output logic [ptst_pkg::CODE_W-1:0]   error_latch,
    output logic                          last
);

    ptst_pkg::ptst_cmd_t  cmd;
    ptst_pkg::ptst_stat_t stat;

    ptst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    ptst_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .operation      (operation),
        .task_tag       (task_tag),
        .first_delay    (first_delay),
        .repeat_period  (repeat_period),
        .slot_to_delete (slot_to_delete),
        .result_valid   (result_valid),
        .slot_index     (slot_index),
        .run_tag        (run_tag),
        .run_valid      (run_valid),
        .status         (status),
        .error_latch    (error_latch),
        .last           (last)
    );

endmodule

// ----- rtl/core/ptst_ram.sv -----
// ----------------------------------------------------------------------------
// ptst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ptst_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptst_ctrl
// Sequencer for the scheduler table: picks the walk for each operation.
// ----------------------------------------------------------------------------
module ptst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           operation,
    input  ptst_pkg::ptst_stat_t stat,
    output ptst_pkg::ptst_cmd_t  cmd,
    output logic                 busy
);

    ptst_pkg::ptst_state_t state_reg;
    ptst_pkg::ptst_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ptst_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (ptst_pkg::ptst_op_t'(operation))
                        ptst_pkg::OP_ADD:    state_next = ptst_pkg::ST_ADD;
                        ptst_pkg::OP_DELETE: state_next = ptst_pkg::ST_DELETE;
                        default:             state_next = ptst_pkg::ST_WALK;
                    endcase
                end
            end
            ptst_pkg::ST_ADD:
            begin
                cmd.add_step = 1'b1;
                if (stat.add_done)
                begin
                    state_next = ptst_pkg::ST_IDLE;
                end
            end
            ptst_pkg::ST_DELETE:
            begin
                cmd.delete_step = 1'b1;
                state_next      = ptst_pkg::ST_IDLE;
            end
            ptst_pkg::ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ptst_pkg::ST_FINISH;
                end
            end
            ptst_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ptst_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ptst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ptst_dpath.sv -----
// ----------------------------------------------------------------------------
// ptst_dpath
// Slot store, valid bits, walk counter and result registers of the table.
// ----------------------------------------------------------------------------
module ptst_dpath #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptst_pkg::ptst_cmd_t                 cmd,
    output ptst_pkg::ptst_stat_t                stat,
    input  logic [1:0]                          operation,
    input  logic [ptst_pkg::TAG_W-1:0]          task_tag,
    input  logic [ptst_pkg::TIME_W-1:0]         first_delay,
    input  logic [ptst_pkg::TIME_W-1:0]         repeat_period,
    input  logic [ptst_pkg::DEL_W-1:0]          slot_to_delete,
    output logic                                result_valid,
    output logic [ptst_pkg::SLOT_W-1:0]         slot_index,
    output logic [ptst_pkg::TAG_W-1:0]          run_tag,
    output logic                                run_valid,
    output logic [ptst_pkg::CODE_W-1:0]         status,
    output logic [ptst_pkg::CODE_W-1:0]         error_latch,
    output logic                                last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int EW = $bits(ptst_pkg::ptst_entry_t);

    // Input word held for the duration of the operation.
    ptst_pkg::ptst_op_t                op_reg, op_next;
    logic [ptst_pkg::TAG_W-1:0]        tag_in_reg, tag_in_next;
    logic [ptst_pkg::TIME_W-1:0]       delay_in_reg, delay_in_next;
    logic [ptst_pkg::TIME_W-1:0]       period_in_reg, period_in_next;
    logic [ptst_pkg::DEL_W-1:0]        del_in_reg, del_in_next;

    logic [NUM_SLOTS-1:0]              valid_reg, valid_next;
    logic [CW-1:0]                     scan_reg, scan_next;
    logic                              rd_vld_reg, rd_vld_next;
    logic [IW-1:0]                     rd_idx_reg, rd_idx_next;
    logic [ptst_pkg::CODE_W-1:0]       sticky_reg, sticky_next;
    logic [ptst_pkg::RUN_CNT_W-1:0]    nres_reg, nres_next;

    // A dispatched slot is held back one step so the final one can carry last.
    logic                              held_vld_reg, held_vld_next;
    logic [IW-1:0]                     held_idx_reg, held_idx_next;
    logic [ptst_pkg::TAG_W-1:0]        held_tag_reg, held_tag_next;

    logic                              out_vld_reg, out_vld_next;
    logic [ptst_pkg::SLOT_W-1:0]       out_idx_reg, out_idx_next;
    logic [ptst_pkg::TAG_W-1:0]        out_tag_reg, out_tag_next;
    logic                              out_run_reg, out_run_next;
    logic [ptst_pkg::CODE_W-1:0]       out_status_reg, out_status_next;
    logic [ptst_pkg::CODE_W-1:0]       out_latch_reg, out_latch_next;
    logic                              out_last_reg, out_last_next;

    logic                              ram_we;
    logic [IW-1:0]                     ram_waddr;
    ptst_pkg::ptst_entry_t             wr_entry;
    logic                              ram_re;
    logic [EW-1:0]                     ram_rdata;
    ptst_pkg::ptst_entry_t             rd_entry;

    logic [IW-1:0]                     scan_idx;
    logic                              scan_end;
    logic [IW+ptst_pkg::DEL_W-1:0]     del_wide;
    logic [IW-1:0]                     del_idx;
    logic                              del_in_range;
    logic                              del_ok;
    logic                              proc_valid;

    ptst_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (scan_idx),
        .rdata (ram_rdata)
    );

    assign rd_entry     = ptst_pkg::ptst_entry_t'(ram_rdata);
    assign scan_idx     = scan_reg[IW-1:0];
    assign scan_end     = (scan_reg == CW'(NUM_SLOTS));
    assign del_wide     = {{IW{1'b0}}, del_in_reg};
    assign del_idx      = del_wide[IW-1:0];
    assign del_in_range = (int'(del_in_reg) < NUM_SLOTS);
    assign del_ok       = del_in_range && valid_reg[del_idx];
    assign proc_valid   = rd_vld_reg && valid_reg[rd_idx_reg];

    assign stat.add_done  = scan_end || !valid_reg[scan_idx];
    assign stat.walk_done = scan_end && !rd_vld_reg;

    always_comb
    begin
        op_next         = op_reg;
        tag_in_next     = tag_in_reg;
        delay_in_next   = delay_in_reg;
        period_in_next  = period_in_reg;
        del_in_next     = del_in_reg;
        valid_next      = valid_reg;
        scan_next       = scan_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        sticky_next     = sticky_reg;
        nres_next       = nres_reg;
        held_vld_next   = held_vld_reg;
        held_idx_next   = held_idx_reg;
        held_tag_next   = held_tag_reg;
        out_vld_next    = 1'b0;
        out_idx_next    = out_idx_reg;
        out_tag_next    = out_tag_reg;
        out_run_next    = out_run_reg;
        out_status_next = out_status_reg;
        out_latch_next  = out_latch_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = scan_idx;
        ram_re          = 1'b0;
        wr_entry        = rd_entry;

        if (cmd.load)
        begin
            op_next        = ptst_pkg::ptst_op_t'(operation);
            tag_in_next    = task_tag;
            delay_in_next  = first_delay;
            period_in_next = repeat_period;
            del_in_next    = slot_to_delete;
            scan_next      = '0;
            nres_next      = '0;
            held_vld_next  = 1'b0;
        end

        if (cmd.add_step)
        begin
            if (scan_end)
            begin
                sticky_next     = ptst_pkg::LATCH_TOO_MANY;
                out_vld_next    = 1'b1;
                out_idx_next    = ptst_pkg::SLOT_W'(NUM_SLOTS);
                out_tag_next    = '0;
                out_run_next    = 1'b0;
                out_status_next = ptst_pkg::STATUS_FULL;
                out_latch_next  = ptst_pkg::LATCH_TOO_MANY;
                out_last_next   = 1'b1;
            end
            else if (!valid_reg[scan_idx])
            begin
                ram_we               = 1'b1;
                wr_entry.tag         = tag_in_reg;
                wr_entry.delay       = delay_in_reg;
                wr_entry.period      = period_in_reg;
                wr_entry.pending     = '0;
                valid_next[scan_idx] = 1'b1;
                out_vld_next         = 1'b1;
                out_idx_next         = ptst_pkg::SLOT_W'(scan_reg);
                out_tag_next         = '0;
                out_run_next         = 1'b0;
                out_status_next      = ptst_pkg::STATUS_OK;
                out_latch_next       = sticky_reg;
                out_last_next        = 1'b1;
            end
            else
            begin
                scan_next = scan_reg + CW'(1);
            end
        end

        if (cmd.delete_step)
        begin
            if (del_in_range)
            begin
                valid_next[del_idx] = 1'b0;
            end
            out_vld_next  = 1'b1;
            out_idx_next  = ptst_pkg::SLOT_W'(del_in_reg);
            out_tag_next  = '0;
            out_run_next  = 1'b0;
            out_last_next = 1'b1;
            if (del_ok)
            begin
                out_status_next = ptst_pkg::STATUS_OK;
                out_latch_next  = sticky_reg;
            end
            else
            begin
                sticky_next     = ptst_pkg::LATCH_CANNOT_DELETE;
                out_status_next = ptst_pkg::STATUS_EMPTY;
                out_latch_next  = ptst_pkg::LATCH_CANNOT_DELETE;
            end
        end

        if (cmd.walk_step)
        begin
            // Issue the read of the next slot while the previous one is updated.
            if (!scan_end)
            begin
                ram_re      = 1'b1;
                scan_next   = scan_reg + CW'(1);
                rd_vld_next = 1'b1;
                rd_idx_next = scan_idx;
            end

            ram_waddr = rd_idx_reg;
            if (op_reg == ptst_pkg::OP_TICK)
            begin
                if (proc_valid)
                begin
                    ram_we = 1'b1;
                    if (rd_entry.delay == '0)
                    begin
                        if (rd_entry.pending != '1)
                        begin
                            wr_entry.pending = rd_entry.pending + 1'b1;
                        end
                        wr_entry.delay = rd_entry.period;
                    end
                    else
                    begin
                        wr_entry.delay = rd_entry.delay - 1'b1;
                    end
                end
            end
            else
            begin
                if (proc_valid && (rd_entry.pending != '0)
                    && (nres_reg < ptst_pkg::RUN_CNT_W'(ptst_pkg::MAX_RUNS)))
                begin
                    ram_we           = 1'b1;
                    wr_entry.pending = rd_entry.pending - 1'b1;
                    if (rd_entry.period == '0)
                    begin
                        valid_next[rd_idx_reg] = 1'b0;
                    end
                    if (held_vld_reg)
                    begin
                        out_vld_next    = 1'b1;
                        out_idx_next    = ptst_pkg::SLOT_W'(held_idx_reg);
                        out_tag_next    = held_tag_reg;
                        out_run_next    = 1'b1;
                        out_status_next = ptst_pkg::STATUS_OK;
                        out_latch_next  = ptst_pkg::LATCH_NONE;
                        out_last_next   = 1'b0;
                    end
                    held_vld_next = 1'b1;
                    held_idx_next = rd_idx_reg;
                    held_tag_next = rd_entry.tag;
                    nres_next     = nres_reg + ptst_pkg::RUN_CNT_W'(1);
                end
            end
        end

        if (cmd.finish)
        begin
            out_vld_next    = 1'b1;
            out_status_next = ptst_pkg::STATUS_OK;
            out_last_next   = 1'b1;
            if (op_reg == ptst_pkg::OP_TICK)
            begin
                out_idx_next   = ptst_pkg::SLOT_W'(NUM_SLOTS);
                out_tag_next   = '0;
                out_run_next   = 1'b0;
                out_latch_next = sticky_reg;
            end
            else
            begin
                sticky_next    = ptst_pkg::LATCH_NONE;
                out_latch_next = ptst_pkg::LATCH_NONE;
                held_vld_next  = 1'b0;
                if (held_vld_reg)
                begin
                    out_idx_next = ptst_pkg::SLOT_W'(held_idx_reg);
                    out_tag_next = held_tag_reg;
                    out_run_next = 1'b1;
                end
                else
                begin
                    out_idx_next = ptst_pkg::SLOT_W'(NUM_SLOTS);
                    out_tag_next = '0;
                    out_run_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            scan_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            sticky_reg   <= ptst_pkg::LATCH_NONE;
            nres_reg     <= '0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            scan_reg     <= scan_next;
            rd_vld_reg   <= rd_vld_next;
            sticky_reg   <= sticky_next;
            nres_reg     <= nres_next;
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        tag_in_reg     <= tag_in_next;
        delay_in_reg   <= delay_in_next;
        period_in_reg  <= period_in_next;
        del_in_reg     <= del_in_next;
        rd_idx_reg     <= rd_idx_next;
        held_idx_reg   <= held_idx_next;
        held_tag_reg   <= held_tag_next;
        out_idx_reg    <= out_idx_next;
        out_tag_reg    <= out_tag_next;
        out_run_reg    <= out_run_next;
        out_status_reg <= out_status_next;
        out_latch_reg  <= out_latch_next;
        out_last_reg   <= out_last_next;
    end

    assign result_valid = out_vld_reg;
    assign slot_index   = out_idx_reg;
    assign run_tag      = out_tag_reg;
    assign run_valid    = out_run_reg;
    assign status       = out_status_reg;
    assign error_latch  = out_latch_reg;
    assign last         = out_last_reg;

endmodule

// ----- tb/sv/ptst_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptst_checker
// Watches the command and result channels of the scheduler table, keeps its
// own copy of the slot table, and checks every result word in order.
// ----------------------------------------------------------------------------
module ptst_checker #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [ptst_pkg::TAG_W-1:0]    task_tag,
    input  logic [ptst_pkg::TIME_W-1:0]   first_delay,
    input  logic [ptst_pkg::TIME_W-1:0]   repeat_period,
    input  logic [ptst_pkg::DEL_W-1:0]    slot_to_delete,
    input  logic                          result_valid,
    input  logic [ptst_pkg::SLOT_W-1:0]   slot_index,
    input  logic [ptst_pkg::TAG_W-1:0]    run_tag,
    input  logic                          run_valid,
    input  logic [ptst_pkg::CODE_W-1:0]   status,
    input  logic [ptst_pkg::CODE_W-1:0]   error_latch,
    input  logic                          last,
    input  logic                          drain_check,
    output int                            words_waiting,
    output int                            results_checked,
    output int                            runs_checked,
    output int                            fail_count
);

    import ptst_pkg::*;

    localparam int MAX_REPORTS = 40;
    localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(NUM_SLOTS);

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic              run;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] latch;
        logic              is_last;
    } sched_result_t;

    // Shadow copy of the slot table.
    logic              task_live  [NUM_SLOTS];
    logic [TAG_W-1:0]  task_label [NUM_SLOTS];
    logic [TIME_W-1:0] countdown  [NUM_SLOTS];
    logic [TIME_W-1:0] reload     [NUM_SLOTS];
    logic [RUNS_W-1:0] runs_owed  [NUM_SLOTS];
    logic [CODE_W-1:0] sticky_err;

    sched_result_t due_results[$];
    sched_result_t want;
    bit            drain_reported;

    task automatic report_mismatch(input string msg);
        begin
            if (fail_count < MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $time, msg);
            fail_count++;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
        begin
            if (got !== exp_val)
                report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                          results_checked, name, got, exp_val));
        end
    endtask

    function automatic void empty_slot(input int s);
        task_live[s]  = 1'b0;
        task_label[s] = '0;
        countdown[s]  = '0;
        reload[s]     = '0;
        runs_owed[s]  = '0;
    endfunction

    // The latch value must already be final when this is called.
    function automatic void expect_result(input logic [SLOT_W-1:0] slot,
                                          input logic [TAG_W-1:0] tag,
                                          input logic run,
                                          input logic [CODE_W-1:0] code,
                                          input logic fin);
        sched_result_t r;
        r.slot    = slot;
        r.tag     = tag;
        r.run     = run;
        r.code    = code;
        r.latch   = sticky_err;
        r.is_last = fin;
        due_results.push_back(r);
    endfunction

    function automatic void predict_word(input ptst_op_t op,
                                         input logic [TAG_W-1:0] tag,
                                         input logic [TIME_W-1:0] dly,
                                         input logic [TIME_W-1:0] per,
                                         input logic [DEL_W-1:0] victim);
        int s;
        int found;
        int count;
        int ready_slot [MAX_RUNS];
        logic [TAG_W-1:0] ready_tag [MAX_RUNS];
        found = NUM_SLOTS;
        count = 0;
        case (op)
            OP_ADD: begin
                for (s = NUM_SLOTS - 1; s >= 0; s--)
                    if (!task_live[s])
                        found = s;
                if (found == NUM_SLOTS) begin
                    sticky_err = LATCH_TOO_MANY;
                    expect_result(NO_SLOT, '0, 1'b0, STATUS_FULL, 1'b1);
                end
                else begin
                    task_live[found]  = 1'b1;
                    task_label[found] = tag;
                    countdown[found]  = dly;
                    reload[found]     = per;
                    runs_owed[found]  = '0;
                    expect_result(SLOT_W'(found), '0, 1'b0, STATUS_OK, 1'b1);
                end
            end
            OP_DELETE: begin
                if (int'(victim) >= NUM_SLOTS) begin
                    sticky_err = LATCH_CANNOT_DELETE;
                    expect_result(SLOT_W'(victim), '0, 1'b0, STATUS_EMPTY, 1'b1);
                end
                else if (!task_live[victim]) begin
                    // An empty slot is still wiped, but the delete is flagged.
                    sticky_err = LATCH_CANNOT_DELETE;
                    empty_slot(int'(victim));
                    expect_result(SLOT_W'(victim), '0, 1'b0, STATUS_EMPTY, 1'b1);
                end
                else begin
                    empty_slot(int'(victim));
                    expect_result(SLOT_W'(victim), '0, 1'b0, STATUS_OK, 1'b1);
                end
            end
            OP_TICK: begin
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (task_live[s]) begin
                        if (countdown[s] == '0) begin
                            if (runs_owed[s] != '1)
                                runs_owed[s]++;
                            countdown[s] = reload[s];
                        end
                        else begin
                            countdown[s]--;
                        end
                    end
                end
                expect_result(NO_SLOT, '0, 1'b0, STATUS_OK, 1'b1);
            end
            default: begin
                sticky_err = LATCH_NONE;
                for (s = 0; s < NUM_SLOTS && count < MAX_RUNS; s++) begin
                    if (runs_owed[s] != '0) begin
                        ready_slot[count] = s;
                        ready_tag[count]  = task_label[s];
                        count++;
                        runs_owed[s]--;
                        // A one-shot task leaves the table once it has run.
                        if (reload[s] == '0)
                            empty_slot(s);
                    end
                end
                if (count == 0)
                    expect_result(NO_SLOT, '0, 1'b0, STATUS_OK, 1'b1);
                for (s = 0; s < count; s++)
                    expect_result(SLOT_W'(ready_slot[s]), ready_tag[s], 1'b1, STATUS_OK,
                                  s == count - 1);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++)
                empty_slot(s);
            sticky_err = LATCH_NONE;
            due_results.delete();
            words_waiting = 0;
        end
        else begin
            if (start && !busy)
                predict_word(ptst_op_t'(operation), task_tag, first_delay, repeat_period,
                             slot_to_delete);
            if (result_valid) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word, slot_index %0d",
                                              slot_index));
                end
                else begin
                    want = due_results.pop_front();
                    check_field("slot_index", 16'(slot_index), 16'(want.slot));
                    check_field("run_tag", 16'(run_tag), 16'(want.tag));
                    check_field("run_valid", 16'(run_valid), 16'(want.run));
                    check_field("status", 16'(status), 16'(want.code));
                    check_field("error_latch", 16'(error_latch), 16'(want.latch));
                    check_field("last", 16'(last), 16'(want.is_last));
                    if (want.run)
                        runs_checked++;
                    results_checked++;
                end
            end
            if (drain_check && !drain_reported) begin
                drain_reported = 1'b1;
                if (due_results.size() != 0)
                    report_mismatch($sformatf("%0d result words never arrived",
                                              due_results.size()));
            end
            words_waiting = due_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_periodic_task_scheduler_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_task_scheduler_table
// Drives add, delete, tick and dispatch commands in random bursts: a directed
// opening, a table fill, a random mix and a tick run that piles up pending
// runs on a one-shot task. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_periodic_task_scheduler_table;

    import ptst_pkg::*;

    localparam int  NUM_SLOTS      = 32;
    localparam int  CLK_PERIOD     = 2;
    localparam int  RANDOM_WORDS   = 122;
    localparam int  ONE_SHOT_TICKS = 20;
    localparam int  DRAIN_LIMIT    = 5000;
    localparam int  RUN_LIMIT_NS   = 1000000;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic [1:0]          operation      = OP_TICK;
    logic [TAG_W-1:0]    task_tag       = '0;
    logic [TIME_W-1:0]   first_delay    = '0;
    logic [TIME_W-1:0]   repeat_period  = '0;
    logic [DEL_W-1:0]    slot_to_delete = '0;
    logic                drain_check    = 1'b0;

    logic                busy;
    logic                result_valid;
    logic [SLOT_W-1:0]   slot_index;
    logic [TAG_W-1:0]    run_tag;
    logic                run_valid;
    logic [CODE_W-1:0]   status;
    logic [CODE_W-1:0]   error_latch;
    logic                last;

    int words_waiting;
    int results_checked;
    int runs_checked;
    int fail_count;
    int words_sent;
    int burst_left;

    periodic_task_scheduler_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .task_tag       (task_tag),
        .first_delay    (first_delay),
        .repeat_period  (repeat_period),
        .slot_to_delete (slot_to_delete),
        .result_valid   (result_valid),
        .slot_index     (slot_index),
        .run_tag        (run_tag),
        .run_valid      (run_valid),
        .status         (status),
        .error_latch    (error_latch),
        .last           (last)
    );

    ptst_checker #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .task_tag        (task_tag),
        .first_delay     (first_delay),
        .repeat_period   (repeat_period),
        .slot_to_delete  (slot_to_delete),
        .result_valid    (result_valid),
        .slot_index      (slot_index),
        .run_tag         (run_tag),
        .run_valid       (run_valid),
        .status          (status),
        .error_latch     (error_latch),
        .last            (last),
        .drain_check     (drain_check),
        .words_waiting   (words_waiting),
        .results_checked (results_checked),
        .runs_checked    (runs_checked),
        .fail_count      (fail_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Holds the word until it is taken, then either keeps start high for the
    // next word of the burst or drops it for a random gap.
    task automatic send_word(input ptst_op_t op, input logic [TAG_W-1:0] tag,
                             input logic [TIME_W-1:0] dly, input logic [TIME_W-1:0] per,
                             input logic [DEL_W-1:0] victim);
        begin
            start          <= 1'b1;
            operation      <= op;
            task_tag       <= tag;
            first_delay    <= dly;
            repeat_period  <= per;
            slot_to_delete <= victim;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            words_sent++;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 45))
                    @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(0, 8);
            end
        end
    endtask

    // Mostly short times so that tasks come due, with the extremes mixed in.
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(0, 6));
        endcase
    endfunction

    task automatic send_random_word();
        int       pick;
        ptst_op_t op;
        begin
            pick = $urandom_range(0, 19);
            if (pick < 7)
                op = OP_ADD;
            else if (pick < 10)
                op = OP_DELETE;
            else if (pick < 17)
                op = OP_TICK;
            else
                op = OP_DISPATCH;
            send_word(op, TAG_W'($urandom), pick_time(), pick_time(),
                      DEL_W'($urandom_range(0, NUM_SLOTS - 1)));
        end
    endtask

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("** periodic_task_scheduler_table: FAILED **");
        $finish;
    end

    initial
    begin
        int waited;
        waited     = 0;
        burst_left = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // Directed opening: empty table, error latch set and cleared, extremes.
        send_word(OP_DISPATCH, '0, '0, '0, '0);
        send_word(OP_DELETE, '0, '0, '0, 5'd0);
        send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_ADD, 8'hFF, 16'h0000, 16'h0000, '0);
        send_word(OP_DISPATCH, '0, '0, '0, '0);
        send_word(OP_ADD, 8'h00, 16'hFFFF, 16'hFFFF, '0);
        send_word(OP_ADD, 8'hA5, 16'h0001, 16'h0002, '0);
        send_word(OP_ADD, 8'h5A, 16'h0000, 16'h0001, '0);
        send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_DISPATCH, '0, '0, '0, '0);
        send_word(OP_DISPATCH, '0, '0, '0, '0);
        send_word(OP_DELETE, '0, '0, '0, 5'd31);
        send_word(OP_DELETE, '0, '0, '0, 5'd1);
        send_word(OP_DELETE, '0, '0, '0, 5'd2);
        send_word(OP_ADD, 8'h3C, 16'hA5A5, 16'h5A5A, '0);
        send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_DISPATCH, '0, '0, '0, '0);

        // Fill the table past its end so that adds get refused.
        repeat (NUM_SLOTS + 2)
            send_word(OP_ADD, TAG_W'($urandom), pick_time(), pick_time(), '0);
        send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_DISPATCH, '0, '0, '0, '0);

        repeat (RANDOM_WORDS)
            send_random_word();

        // A one-shot task left waiting gains a run on every tick until it is
        // dispatched; the periodic ones with short periods pile up runs too.
        send_word(OP_DELETE, '0, '0, '0, DEL_W'($urandom_range(0, NUM_SLOTS - 1)));
        send_word(OP_ADD, TAG_W'($urandom), '0, '0, '0);
        repeat (ONE_SHOT_TICKS)
            send_word(OP_TICK, '0, '0, '0, '0);
        send_word(OP_DISPATCH, '0, '0, '0, '0);
        send_word(OP_DISPATCH, '0, '0, '0, '0);
        start <= 1'b0;

        while (words_waiting != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (NUM_SLOTS + 8)
            @(posedge clk);
        drain_check <= 1'b1;
        repeat (2)
            @(posedge clk);

        $display("Sent %0d command words (adds, deletes, ticks, dispatches).", words_sent);
        $display("Checked %0d result words, %0d of them task runs.", results_checked,
                 runs_checked);
        if (fail_count == 0)
            $display("** periodic_task_scheduler_table: PASSED **");
        else
            $display("** periodic_task_scheduler_table: FAILED **");
        $finish;
    end

endmodule
